/* rtl/mbgd_pkg.sv */
// ----------------------------------------------------------------------------
// mbgd_pkg
// Types and constants shared by the multi-button gesture detector.
// ----------------------------------------------------------------------------
package mbgd_pkg;

  // Event codes
  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_COMBO_LONG  = 3'd1;
  localparam logic [2:0] EV_LONG        = 3'd2;
  localparam logic [2:0] EV_CLICK       = 3'd3;
  localparam logic [2:0] EV_DOUBLE      = 3'd4;
  localparam logic [2:0] EV_PENDING     = 3'd5;
  localparam logic [2:0] EV_COMBO_CLICK = 3'd6;
  localparam logic [2:0] EV_PRESS_START = 3'd7;

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_LONG_PRESS  = 3'd1;
  localparam logic [2:0] REG_DOUBLE      = 3'd2;
  localparam logic [2:0] REG_COMBO_LONG  = 3'd3;
  localparam logic [2:0] REG_LONG_EN     = 3'd4;
  localparam logic [2:0] REG_DOUBLE_EN   = 3'd5;
  localparam logic [2:0] REG_REPEAT      = 3'd6;
  localparam logic [2:0] REG_ACTIVE_LOW  = 3'd7;

  // Number of buttons that have pins and mask bits
  localparam int unsigned PIN_COUNT = 4;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  pin_levels;
  } in_item_t;

  typedef struct packed {
    logic [1:0] button_index;
    logic [2:0] event_kind;
    logic [3:0] combo_mask;
    logic       last_of_poll;
  } out_item_t;

  // Per-button state held in the state memory
  typedef struct packed {
    logic        raw_before;
    logic        debounced;
    logic [31:0] change_time;
    logic [31:0] press_start_time;
    logic [31:0] click_time;
    logic        long_done;
  } btn_entry_t;

  // State shared between buttons
  typedef struct packed {
    logic [3:0] held_set;
    logic       combo_happened;
  } shared_t;

  typedef struct packed {
    logic [15:0] debounce_ms;
    logic [15:0] long_press_ms;
    logic [15:0] double_press_ms;
    logic [15:0] combo_long_ms;
    logic [3:0]  long_enable_mask;
    logic [3:0]  double_enable_mask;
    logic [3:0]  repeat_long_mask;
    logic [3:0]  active_low_mask;
  } cfg_t;

  // Mask bit of a button; buttons beyond the pinned ones read as clear
  function automatic logic mask_bit(input logic [3:0] m, input logic [4:0] i);
    mask_bit = (i < 5'(PIN_COUNT)) ? m[i[1:0]] : 1'b0;
  endfunction

endpackage

/* rtl/mbgd_ram.sv */
// ----------------------------------------------------------------------------
// mbgd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

/* rtl/mbgd_eval.sv */
// ----------------------------------------------------------------------------
// mbgd_eval
// Debounce and gesture decision for one button: takes the entry read from
// the state memory and the shared state, returns updated state and event.
// ----------------------------------------------------------------------------
module mbgd_eval
  import mbgd_pkg::*;
(
  input  cfg_t        cfg,
  input  logic [31:0] now_ms,
  input  logic        pin,
  input  logic [4:0]  idx,
  input  btn_entry_t  ent,
  input  shared_t     shr,
  output btn_entry_t  ent_nxt,
  output shared_t     shr_nxt,
  output logic [2:0]  kind,
  output logic [3:0]  cmask
);

  logic        raw;
  logic        deb_now;
  logic [31:0] since_change;
  logic [31:0] held_time;
  logic [31:0] since_click;
  logic        multi;
  logic        combo_long;
  logic        single_long;
  logic        holding;
  logic        released;
  logic        started;
  logic        rel;
  logic        dbl;
  logic        registered;
  logic        elapsed;

  assign raw          = pin ^ mask_bit(cfg.active_low_mask, idx);
  assign since_change = now_ms - ent.change_time;
  assign held_time    = now_ms - ent.press_start_time;
  assign since_click  = now_ms - ent.click_time;
  assign multi        = ($countones(shr.held_set) >= 2);
  assign combo_long   = multi && (cfg.combo_long_ms != 16'd0) &&
                        (held_time >= 32'(cfg.combo_long_ms));
  assign single_long  = mask_bit(cfg.long_enable_mask, idx) &&
                        (ent.press_start_time != 32'd0) &&
                        (held_time >= 32'(cfg.long_press_ms)) && !multi;
  assign deb_now      = (raw != ent.raw_before && since_change >= 32'(cfg.debounce_ms))
                        ? raw : ent.debounced;
  assign holding      = ent.debounced && deb_now;
  assign released     = ent.debounced && !deb_now;
  assign started      = !ent.debounced && deb_now;
  assign rel          = released && !shr.combo_happened && !single_long && !ent.long_done;
  assign dbl          = mask_bit(cfg.double_enable_mask, idx);
  assign registered   = (ent.click_time != 32'd0);
  assign elapsed      = (since_click > 32'(cfg.double_press_ms));

  // Priority chain
  always_comb begin
    ent_nxt            = ent;
    ent_nxt.raw_before = raw;
    ent_nxt.debounced  = deb_now;
    if (raw != ent.raw_before && since_change >= 32'(cfg.debounce_ms)) begin
      ent_nxt.change_time = now_ms;
    end
    shr_nxt = shr;
    kind    = EV_NONE;
    cmask   = 4'd0;
    if (holding && !shr.combo_happened && combo_long) begin
      kind                   = EV_COMBO_LONG;
      cmask                  = shr.held_set;
      shr_nxt.held_set       = 4'd0;
      shr_nxt.combo_happened = 1'b1;
    end else if (holding && !shr.combo_happened && single_long) begin
      kind                     = EV_LONG;
      shr_nxt.held_set         = 4'd0;
      ent_nxt.long_done        = 1'b1;
      ent_nxt.press_start_time = mask_bit(cfg.repeat_long_mask, idx) ? now_ms : 32'd0;
    end else if ((rel && !multi && !dbl) || (registered && elapsed)) begin
      kind                     = EV_CLICK;
      shr_nxt.held_set         = 4'd0;
      ent_nxt.press_start_time = 32'd0;
      ent_nxt.click_time       = 32'd0;
    end else if (rel && !multi && dbl && registered && !elapsed) begin
      kind                     = EV_DOUBLE;
      shr_nxt.held_set         = 4'd0;
      ent_nxt.press_start_time = 32'd0;
      ent_nxt.click_time       = 32'd0;
    end else if (rel && !multi && !registered) begin
      kind               = EV_PENDING;
      ent_nxt.click_time = now_ms;
    end else if (rel) begin
      kind                     = EV_COMBO_CLICK;
      cmask                    = shr.held_set;
      shr_nxt.held_set         = 4'd0;
      shr_nxt.combo_happened   = 1'b1;
      ent_nxt.press_start_time = 32'd0;
    end else if (started) begin
      kind                     = EV_PRESS_START;
      if (idx < 5'(PIN_COUNT)) begin
        shr_nxt.held_set[idx[1:0]] = 1'b1;
      end
      shr_nxt.combo_happened   = 1'b0;
      ent_nxt.long_done        = 1'b0;
      ent_nxt.press_start_time = now_ms;
    end
  end

endmodule

/* rtl/multi_button_gesture_detector.sv */
// ----------------------------------------------------------------------------
// multi_button_gesture_detector
// Debounces a set of buttons and reports one gesture event per button per poll.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_data carry one poll (time stamp and pin levels). A transfer
//    takes place when in_valid is high and in_stall is low.
//  - Each poll produces BUTTON_COUNT results on out_valid/out_data, in button
//    order, the last one flagged with last_of_poll.
//  - Per-button state sits in a small RAM; each button is read, updated and
//    written back, one button per cycle while the receiver does not stall.
//    in_stall is high while a poll is being walked.
//  - The first result enters the output register after button 0 is read from the RAM.
//  - When out_stall is high and a result is pending, the walk pauses and the result holds.
//  - Reset (rst_n low, synchronous) clears configuration to defaults and
//    marks every memory entry invalid, which reads as all-zero state.
//  - cfg_we/cfg_index/cfg_data write a register; the user must do so only while the block is idle (not enforced).
// ----------------------------------------------------------------------------
module multi_button_gesture_detector
  import mbgd_pkg::*;
#(
  parameter int BUTTON_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam int ENT_W = $bits(btn_entry_t);

  typedef enum logic {ST_IDLE, ST_PROC} state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  idx_r;
  logic [31:0]       now_r;
  logic [3:0]        pins_r;
  logic [BUTTON_COUNT-1:0] valid_r;
  logic              rvalid_r;
  shared_t           shared_r;
  cfg_t              cfg_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic              in_xfer;
  logic              slot_free;
  logic              step;
  logic              is_last;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  rd_data;
  btn_entry_t        ent;
  btn_entry_t        ent_nxt;
  shared_t           shared_nxt;
  logic [2:0]        kind;
  logic [3:0]        cmask;
  logic [4:0]        idx_ext;
  logic              pin;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign step      = (state_r == ST_PROC) && slot_free;
  assign is_last   = (idx_r == IDX_W'(BUTTON_COUNT - 1));
  assign idx_ext   = 5'(idx_r);
  assign pin       = mask_bit(pins_r, idx_ext);

  // Read the first button at transfer, the next one with each step
  assign rd_en   = in_xfer || (step && !is_last);
  assign rd_addr = in_xfer ? '0 : idx_r + IDX_W'(1);

  // Entries never written read as reset state
  assign ent = rvalid_r ? btn_entry_t'(rd_data) : '0;

  mbgd_ram #(
    .WIDTH(ENT_W),
    .DEPTH(BUTTON_COUNT)
  ) u_state_ram (
    .clk  (clk),
    .we   (step),
    .waddr(idx_r),
    .wdata(ENT_W'(ent_nxt)),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  mbgd_eval u_eval (
    .cfg    (cfg_r),
    .now_ms (now_r),
    .pin    (pin),
    .idx    (idx_ext),
    .ent    (ent),
    .shr    (shared_r),
    .ent_nxt(ent_nxt),
    .shr_nxt(shared_nxt),
    .kind   (kind),
    .cmask  (cmask)
  );

  // Control, walk and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      valid_r     <= '0;
      rvalid_r    <= 1'b0;
      shared_r    <= '0;
      out_valid_r <= 1'b0;
      cfg_r.debounce_ms        <= 16'd50;
      cfg_r.long_press_ms      <= 16'd1000;
      cfg_r.double_press_ms    <= 16'd300;
      cfg_r.combo_long_ms      <= 16'd0;
      cfg_r.long_enable_mask   <= 4'd0;
      cfg_r.double_enable_mask <= 4'd0;
      cfg_r.repeat_long_mask   <= 4'd0;
      cfg_r.active_low_mask    <= 4'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEBOUNCE:   cfg_r.debounce_ms        <= cfg_data;
          REG_LONG_PRESS: cfg_r.long_press_ms      <= cfg_data;
          REG_DOUBLE:     cfg_r.double_press_ms    <= cfg_data;
          REG_COMBO_LONG: cfg_r.combo_long_ms      <= cfg_data;
          REG_LONG_EN:    cfg_r.long_enable_mask   <= cfg_data[3:0];
          REG_DOUBLE_EN:  cfg_r.double_enable_mask <= cfg_data[3:0];
          REG_REPEAT:     cfg_r.repeat_long_mask   <= cfg_data[3:0];
          REG_ACTIVE_LOW: cfg_r.active_low_mask    <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (rd_en) begin
        rvalid_r <= valid_r[rd_addr];
      end
      // Output slot fills on a step, empties on a transfer
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            state_r <= ST_PROC;
            idx_r   <= '0;
          end
        end
        ST_PROC: begin
          if (step) begin
            valid_r[idx_r] <= 1'b1;
            shared_r       <= shared_nxt;
            if (is_last) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + IDX_W'(1);
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      now_r  <= in_data.now_ms;
      pins_r <= in_data.pin_levels;
    end
    if (step) begin
      out_data_r.button_index <= 2'(idx_r);
      out_data_r.event_kind   <= kind;
      out_data_r.combo_mask   <= cmask;
      out_data_r.last_of_poll <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
